>>> hdl/hkta_pkg.sv
package hkta_pkg;

  // physical slots in the packed text view
  localparam int SLOT_COUNT = 12;
  localparam int HALF_SLOTS = 6;

  typedef logic [6:0] ascii_t;
  typedef logic [7:0] usage_t;

  localparam usage_t USAGE_A           = 8'h04;
  localparam usage_t USAGE_Z           = 8'h1D;
  localparam usage_t USAGE_1           = 8'h1E;
  localparam usage_t USAGE_0           = 8'h27;
  localparam usage_t USAGE_SPACE       = 8'h2C;
  localparam usage_t USAGE_PUNCT_FIRST = 8'h2D;
  localparam usage_t USAGE_PUNCT_LAST  = 8'h38;

  // 0xe0..0xe7: left ctrl, shift, alt, gui, then the right ones
  localparam logic [4:0] USAGE_MOD_PREFIX = 5'b11100;

  typedef enum logic [1:0] {
    SEL_CTRL  = 2'd0,
    SEL_SHIFT = 2'd1,
    SEL_ALT   = 2'd2,
    SEL_GUI   = 2'd3
  } mod_sel_t;

  localparam ascii_t ASCII_NONE    = 7'h00;
  localparam ascii_t ASCII_LOWER_A = 7'h61;
  localparam ascii_t CASE_OFFSET   = 7'h20;
  localparam ascii_t ASCII_ONE     = 7'h31;
  localparam ascii_t ASCII_ZERO    = 7'h30;
  localparam ascii_t ASCII_SPACE   = 7'h20;

  // - = [ ] \ (none) ; ' ` , . /
  localparam ascii_t PUNCT_PLAIN [12] = '{
    7'h2D, 7'h3D, 7'h5B, 7'h5D, 7'h5C, 7'h00,
    7'h3B, 7'h27, 7'h60, 7'h2C, 7'h2E, 7'h2F
  };
  // _ + { } | (none) : " ~ < > ?
  localparam ascii_t PUNCT_SHIFT [12] = '{
    7'h5F, 7'h2B, 7'h7B, 7'h7D, 7'h7C, 7'h00,
    7'h3A, 7'h22, 7'h7E, 7'h3C, 7'h3E, 7'h3F
  };
  // ! @ # $ % ^ & * ( )
  localparam ascii_t DIGIT_SHIFT [10] = '{
    7'h21, 7'h40, 7'h23, 7'h24, 7'h25,
    7'h5E, 7'h26, 7'h2A, 7'h28, 7'h29
  };

  typedef struct packed {
    logic         char_valid;
    ascii_t       char_code;
    logic         shift_held;
    logic         ctrl_held;
    logic         alt_held;
    logic         gui_held;
    logic [3:0]   text_length;
    logic [47:0]  text_first_six;
    logic [47:0]  text_last_six;
  } res_t;

  // us layout lookup, zero for keys that give no character
  function automatic ascii_t map_usage(usage_t u, logic sh);
    usage_t k;
    ascii_t c;
    c = ASCII_NONE;
    k = '0;
    if (u >= USAGE_A && u <= USAGE_Z) begin
      k = u - USAGE_A;
      c = ASCII_LOWER_A + k[6:0];
      if (sh) begin
        c = c - CASE_OFFSET;
      end
    end else if (u >= USAGE_1 && u <= USAGE_0) begin
      k = u - USAGE_1;
      if (sh) begin
        c = DIGIT_SHIFT[k[3:0]];
      end else if (u == USAGE_0) begin
        c = ASCII_ZERO;
      end else begin
        c = ASCII_ONE + k[6:0];
      end
    end else if (u == USAGE_SPACE) begin
      c = ASCII_SPACE;
    end else if (u >= USAGE_PUNCT_FIRST && u <= USAGE_PUNCT_LAST) begin
      k = u - USAGE_PUNCT_FIRST;
      c = sh ? PUNCT_SHIFT[k[3:0]] : PUNCT_PLAIN[k[3:0]];
    end
    return c;
  endfunction

endpackage

>>> hdl/hkta_key_if.sv
interface hkta_key_if;
  logic                 valid;
  logic                 ready;
  hkta_pkg::usage_t     key_usage;
  logic                 key_pressed;

  modport source (output valid, output key_usage, output key_pressed, input ready);
  modport sink   (input valid, input key_usage, input key_pressed, output ready);
endinterface

>>> hdl/hkta_res_if.sv
interface hkta_res_if;
  logic               valid;
  logic               ready;
  logic               char_valid;
  hkta_pkg::ascii_t   char_code;
  logic               shift_held;
  logic               ctrl_held;
  logic               alt_held;
  logic               gui_held;
  logic [3:0]         text_length;
  logic [47:0]        text_first_six;
  logic [47:0]        text_last_six;

  modport source (
    output valid, output char_valid, output char_code, output shift_held,
    output ctrl_held, output alt_held, output gui_held, output text_length,
    output text_first_six, output text_last_six, input ready
  );
  modport sink (
    input valid, input char_valid, input char_code, input shift_held,
    input ctrl_held, input alt_held, input gui_held, input text_length,
    input text_first_six, input text_last_six, output ready
  );
endinterface

>>> hdl/hid_key_to_ascii_text_log_unit.sv
// channel  | dir | word
// ---------+-----+---------------------------------------------------------
// keys     | in  | key_usage, key_pressed (one keyboard event)
// report   | out | char, modifier flags, text length, packed text
//
// an accepted event updates the flags and text store and loads the report
// register at the same edge, so a new word can enter every cycle that keys.ready
// is high; the single report register is the only stage; keys.ready is low only while
// a report is held and report.ready is low
// rst (synchronous) clears the flags, the count, the store and the report valid
module hid_key_to_ascii_text_log_unit #(
  parameter int TEXT_DEPTH = 12
) (
  input  logic          clk,
  input  logic          rst,
  hkta_key_if.sink      keys,
  hkta_res_if.source    report
);

  localparam int CNT_W = $clog2(TEXT_DEPTH + 1);

  // architectural state
  logic                 shift_flag, ctrl_flag, alt_flag, gui_flag;
  logic [CNT_W-1:0]     text_count;
  hkta_pkg::ascii_t     text_store [TEXT_DEPTH];

  // report stage
  logic                 res_valid;
  hkta_pkg::res_t       res;

  // next values
  logic                 shift_next, ctrl_next, alt_next, gui_next;
  logic [CNT_W-1:0]     text_count_next;
  hkta_pkg::ascii_t     text_store_next [TEXT_DEPTH];
  hkta_pkg::ascii_t     char_next;
  hkta_pkg::ascii_t     slot_view [hkta_pkg::SLOT_COUNT];
  hkta_pkg::res_t       res_next;
  hkta_pkg::mod_sel_t   mod_sel;
  logic                 is_mod;
  logic                 append;
  logic                 full;
  logic                 accept;

  // report register frees up when taken, so input never waits on an empty stage
  assign keys.ready = ~res_valid | report.ready;
  assign accept     = keys.valid & keys.ready;

  // modifier decode: either key of a pair drives the flag, last event wins
  assign is_mod  = (keys.key_usage[7:3] == hkta_pkg::USAGE_MOD_PREFIX);
  assign mod_sel = hkta_pkg::mod_sel_t'(keys.key_usage[1:0]);

  always_comb begin
    shift_next = shift_flag;
    ctrl_next  = ctrl_flag;
    alt_next   = alt_flag;
    gui_next   = gui_flag;
    if (is_mod) begin
      unique case (mod_sel)
        hkta_pkg::SEL_CTRL:  ctrl_next  = keys.key_pressed;
        hkta_pkg::SEL_SHIFT: shift_next = keys.key_pressed;
        hkta_pkg::SEL_ALT:   alt_next   = keys.key_pressed;
        hkta_pkg::SEL_GUI:   gui_next   = keys.key_pressed;
        default:             ctrl_next  = ctrl_flag;
      endcase
    end
  end

  // lookup uses the shift flag already updated by this event
  assign char_next = keys.key_pressed ?
                     hkta_pkg::map_usage(keys.key_usage, shift_next) : hkta_pkg::ASCII_NONE;
  assign append    = (char_next != hkta_pkg::ASCII_NONE);
  assign full      = (text_count == CNT_W'(TEXT_DEPTH));

  // full store: everything moves toward slot 0, new char lands in the last slot
  // otherwise the char goes into the first empty slot
  for (genvar i = 0; i < TEXT_DEPTH; i++) begin : g_slot
    if (i == TEXT_DEPTH - 1) begin : g_last
      always_comb begin
        text_store_next[i] = text_store[i];
        if (append && (full || text_count == CNT_W'(i))) begin
          text_store_next[i] = char_next;
        end
      end
    end else begin : g_inner
      always_comb begin
        text_store_next[i] = text_store[i];
        if (append) begin
          if (full) begin
            text_store_next[i] = text_store[i+1];
          end else if (text_count == CNT_W'(i)) begin
            text_store_next[i] = char_next;
          end
        end
      end
    end
  end

  assign text_count_next = (append && !full) ? text_count + CNT_W'(1) : text_count;

  // packed view: slots past the configured depth read zero
  for (genvar i = 0; i < hkta_pkg::SLOT_COUNT; i++) begin : g_view
    if (i < TEXT_DEPTH) begin : g_used
      assign slot_view[i] = text_store_next[i];
    end else begin : g_unused
      assign slot_view[i] = hkta_pkg::ASCII_NONE;
    end
  end

  always_comb begin
    res_next                = '0;
    res_next.char_valid     = append;
    res_next.char_code      = char_next;
    res_next.shift_held     = shift_next;
    res_next.ctrl_held      = ctrl_next;
    res_next.alt_held       = alt_next;
    res_next.gui_held       = gui_next;
    res_next.text_length    = 4'(text_count_next);
    for (int i = 0; i < hkta_pkg::HALF_SLOTS; i++) begin
      res_next.text_first_six[8*i +: 8] = {1'b0, slot_view[i]};
      res_next.text_last_six[8*i +: 8]  = {1'b0, slot_view[i + hkta_pkg::HALF_SLOTS]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_flag <= 1'b0;
      ctrl_flag  <= 1'b0;
      alt_flag   <= 1'b0;
      gui_flag   <= 1'b0;
      text_count <= '0;
      res_valid  <= 1'b0;
      for (int i = 0; i < TEXT_DEPTH; i++) begin
        text_store[i] <= hkta_pkg::ASCII_NONE;
      end
    end else begin
      if (accept) begin
        shift_flag <= shift_next;
        ctrl_flag  <= ctrl_next;
        alt_flag   <= alt_next;
        gui_flag   <= gui_next;
        text_count <= text_count_next;
        res_valid  <= 1'b1;
        for (int i = 0; i < TEXT_DEPTH; i++) begin
          text_store[i] <= text_store_next[i];
        end
      end else if (report.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // report payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_next;
    end
  end

  assign report.valid          = res_valid;
  assign report.char_valid     = res.char_valid;
  assign report.char_code      = res.char_code;
  assign report.shift_held     = res.shift_held;
  assign report.ctrl_held      = res.ctrl_held;
  assign report.alt_held       = res.alt_held;
  assign report.gui_held       = res.gui_held;
  assign report.text_length    = res.text_length;
  assign report.text_first_six = res.text_first_six;
  assign report.text_last_six  = res.text_last_six;

  // every accepted word shows up in the report register next cycle
  a_accept_reports: assert property (@(posedge clk) disable iff (rst)
    accept |=> res_valid)
    else $error("accepted word produced no report");

  // count never passes the store depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    text_count <= CNT_W'(TEXT_DEPTH))
    else $error("text count beyond depth");

  // count only ever grows by one, and only on an accepted word
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (text_count == $past(text_count)) ||
             ($past(accept) && text_count == $past(text_count) + CNT_W'(1)))
    else $error("text count moved unexpectedly");

  // reported length tracks the count after the word
  a_length_match: assert property (@(posedge clk) disable iff (rst)
    accept |=> report.text_length == 4'(text_count))
    else $error("reported length disagrees with count");

  // a reported character is never the empty code
  a_char_nonzero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.char_valid) |-> res.char_code != hkta_pkg::ASCII_NONE)
    else $error("valid char with empty code");

endmodule

>>> sim/hid_key_to_ascii_text_log_unit_tb.sv
module hid_key_to_ascii_text_log_unit_tb;

  localparam int LOG_DEPTH   = 12;
  localparam int HALF_PERIOD = 4;
  localparam int RESET_CYCLES = 8;
  localparam int HOLD_CYCLES  = 40;     // long report back-pressure stretch
  localparam int DRAIN_CYCLES = 10;     // settle time after the last word
  localparam int CYCLE_LIMIT  = 100000;

  // one row of the directed script: a keyboard event, and where the answer
  // is obvious, the report typed in by hand
  typedef struct {
    hkta_pkg::usage_t usage;
    logic             pressed;
    logic             fixed;
    hkta_pkg::res_t   want;
  } script_row_t;

  localparam int SCRIPT_ROWS = 27;

  logic clk = 1'b0;
  logic rst = 1'b1;

  hkta_key_if keys_if ();
  hkta_res_if rep_if ();

  hid_key_to_ascii_text_log_unit #(
    .TEXT_DEPTH(LOG_DEPTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .keys(keys_if),
    .report(rep_if)
  );

  always #HALF_PERIOD clk = ~clk;

  // shadow copy of the block state
  hkta_pkg::ascii_t log_chars [LOG_DEPTH];
  logic [3:0]       log_len;
  logic             shift_on;
  logic             ctrl_on;
  logic             alt_on;
  logic             gui_on;

  hkta_pkg::res_t reports_due [$];  // reports still owed by the block, oldest first
  int             mismatches = 0;
  bit             gaps_on = 1'b0;   // random idling on both sides
  bit             hold_req = 1'b0;  // asks the report side for a long hold-off
  logic           cur_fixed = 1'b0; // word on the key bus has a hand-typed report
  hkta_pkg::res_t cur_want = '0;

  script_row_t key_script [SCRIPT_ROWS] = '{
    // release of a letter right after reset: nothing at all
    '{8'h04, 1'b0, 1'b1, '0},
    // usage zero, top usage and the code just past the modifiers: no char
    '{8'h00, 1'b1, 1'b1, '0},
    '{8'hFF, 1'b1, 1'b1, '0},
    '{8'hE8, 1'b1, 1'b1, '0},
    // first letter lands in slot 0
    '{8'h04, 1'b1, 1'b1,
      '{1'b1, 7'h61, 1'b0, 1'b0, 1'b0, 1'b0, 4'd1, 48'h61, 48'h0}},
    // left shift only raises the flag
    '{8'hE1, 1'b1, 1'b1,
      '{1'b0, 7'h00, 1'b1, 1'b0, 1'b0, 1'b0, 4'd1, 48'h61, 48'h0}},
    // last letter, shifted
    '{8'h1D, 1'b1, 1'b1,
      '{1'b1, 7'h5A, 1'b1, 1'b0, 1'b0, 1'b0, 4'd2, 48'h5A61, 48'h0}},
    // shifted digit ends and punctuation ends
    '{8'h1E, 1'b1, 1'b0, '0},
    '{8'h27, 1'b1, 1'b0, '0},
    '{8'h2D, 1'b1, 1'b0, '0},
    '{8'h38, 1'b1, 1'b0, '0},
    // right shift release clears the flag the left key set
    '{8'hE5, 1'b0, 1'b0, '0},
    '{8'h27, 1'b1, 1'b0, '0},
    '{8'h1E, 1'b1, 1'b0, '0},
    '{8'h2C, 1'b1, 1'b0, '0},
    '{8'h2D, 1'b1, 1'b0, '0},
    '{8'h31, 1'b1, 1'b0, '0},
    // hole in the punctuation range, enter, and the key past the range
    '{8'h32, 1'b1, 1'b0, '0},
    '{8'h28, 1'b1, 1'b0, '0},
    '{8'h39, 1'b1, 1'b0, '0},
    // modifier presses from both halves, a release from the other half
    '{8'hE0, 1'b1, 1'b0, '0},
    '{8'hE6, 1'b1, 1'b0, '0},
    '{8'hE7, 1'b1, 1'b0, '0},
    '{8'hE4, 1'b0, 1'b0, '0},
    '{8'h1D, 1'b0, 1'b0, '0},
    // twelfth char fills the store, the next one pushes the oldest out
    '{8'h38, 1'b1, 1'b0, '0},
    '{8'h04, 1'b1, 1'b0, '0}
  };

  // us layout lookup written from the key tables, zero when unmapped
  function automatic hkta_pkg::ascii_t us_ascii(hkta_pkg::usage_t u, logic sh);
    string digits_up = "!@#$%^&*()";
    string punct_lo  = "-=[]\\ ;'\140,./";
    string punct_hi  = "_+{}| :\"~<>?";
    hkta_pkg::ascii_t c;
    int k;
    c = hkta_pkg::ASCII_NONE;
    k = int'(u);
    if (k >= int'(hkta_pkg::USAGE_A) && k <= int'(hkta_pkg::USAGE_Z)) begin
      c = hkta_pkg::ascii_t'(k - int'(hkta_pkg::USAGE_A)) + (sh ? 7'h41 : 7'h61);
    end else if (k >= int'(hkta_pkg::USAGE_1) && k <= int'(hkta_pkg::USAGE_0)) begin
      k = k - int'(hkta_pkg::USAGE_1);
      if (sh) begin
        c = hkta_pkg::ascii_t'(digits_up[k]);
      end else begin
        c = (k == 9) ? hkta_pkg::ASCII_ZERO : hkta_pkg::ASCII_ONE + hkta_pkg::ascii_t'(k);
      end
    end else if (u == hkta_pkg::USAGE_SPACE) begin
      c = hkta_pkg::ASCII_SPACE;
    end else if (k >= int'(hkta_pkg::USAGE_PUNCT_FIRST) &&
                 k <= int'(hkta_pkg::USAGE_PUNCT_LAST)) begin
      k = k - int'(hkta_pkg::USAGE_PUNCT_FIRST);
      // slot 5 is the non-us hash key, left unmapped
      if (k != 5) begin
        c = hkta_pkg::ascii_t'(sh ? punct_hi[k] : punct_lo[k]);
      end
    end
    return c;
  endfunction

  // advances the shadow state by one event and builds the report it gives
  function automatic hkta_pkg::res_t next_report(hkta_pkg::usage_t u, logic p);
    hkta_pkg::res_t r;
    hkta_pkg::ascii_t c;
    if (u[7:3] == hkta_pkg::USAGE_MOD_PREFIX) begin
      case (hkta_pkg::mod_sel_t'(u[1:0]))
        hkta_pkg::SEL_CTRL:  ctrl_on = p;
        hkta_pkg::SEL_SHIFT: shift_on = p;
        hkta_pkg::SEL_ALT:   alt_on = p;
        hkta_pkg::SEL_GUI:   gui_on = p;
      endcase
    end
    c = p ? us_ascii(u, shift_on) : hkta_pkg::ASCII_NONE;
    if (c != hkta_pkg::ASCII_NONE) begin
      // full store: shift everything toward slot 0
      if (log_len == LOG_DEPTH) begin
        for (int i = 0; i < LOG_DEPTH - 1; i++) begin
          log_chars[i] = log_chars[i + 1];
        end
        log_len = log_len - 4'd1;
      end
      log_chars[log_len] = c;
      log_len = log_len + 4'd1;
    end
    r = '0;
    r.char_valid  = (c != hkta_pkg::ASCII_NONE);
    r.char_code   = c;
    r.shift_held  = shift_on;
    r.ctrl_held   = ctrl_on;
    r.alt_held    = alt_on;
    r.gui_held    = gui_on;
    r.text_length = log_len;
    for (int i = 0; i < hkta_pkg::HALF_SLOTS; i++) begin
      r.text_first_six[8*i +: 8] = {1'b0, log_chars[i]};
      r.text_last_six[8*i +: 8]  = {1'b0, log_chars[i + hkta_pkg::HALF_SLOTS]};
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [47:0] want_v,
                             input logic [47:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
      mismatches++;
    end
  endtask

  // puts one word on the key bus and holds it until the block takes it
  task automatic offer_key(input hkta_pkg::usage_t u, input logic p, input logic fixed,
                           input hkta_pkg::res_t want);
    while (gaps_on && $urandom_range(99) < 29) begin
      keys_if.valid <= 1'b0;
      @(negedge clk);
    end
    cur_fixed = fixed;
    cur_want  = want;
    keys_if.valid       <= 1'b1;
    keys_if.key_usage   <= u;
    keys_if.key_pressed <= p;
    @(posedge clk);
    while (!keys_if.ready) begin
      @(posedge clk);
    end
    @(negedge clk);
  endtask

  // sender pause: drop valid and wait for every owed report
  task automatic wait_drained();
    keys_if.valid <= 1'b0;
    @(negedge clk);
    while (reports_due.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // random events, mostly printable presses with modifiers toggling in between
  task automatic run_random(input int count);
    int done;
    int sel;
    hkta_pkg::usage_t u;
    logic p;
    done = 0;
    while (done < count) begin
      sel = $urandom_range(99);
      if (sel < 55) begin
        u = hkta_pkg::usage_t'($urandom_range(hkta_pkg::USAGE_A, hkta_pkg::USAGE_PUNCT_LAST));
        p = 1'b1;
      end else if (sel < 75) begin
        u = {hkta_pkg::USAGE_MOD_PREFIX, 3'($urandom_range(7))};
        p = 1'($urandom_range(1));
      end else if (sel < 85) begin
        u = hkta_pkg::usage_t'($urandom_range(hkta_pkg::USAGE_A, hkta_pkg::USAGE_PUNCT_LAST));
        p = 1'b0;
      end else begin
        u = hkta_pkg::usage_t'($urandom_range(255));
        p = 1'($urandom_range(1));
      end
      offer_key(u, p, 1'b0, '0);
      done++;
    end
  endtask

  // report side: random stalls, or a long counted hold-off on request
  initial begin : report_sink
    int hold_left;
    hold_left = 0;
    rep_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        rep_if.ready <= 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        rep_if.ready <= 1'b0;
      end else begin
        rep_if.ready <= !(gaps_on && $urandom_range(99) < 29);
      end
    end
  end

  // predict on every accepted key word, check every accepted report word
  always @(posedge clk) begin
    hkta_pkg::res_t predicted;
    hkta_pkg::res_t want;
    if (!rst) begin
      if (keys_if.valid && keys_if.ready) begin
        predicted = next_report(keys_if.key_usage, keys_if.key_pressed);
        reports_due.push_back(cur_fixed ? cur_want : predicted);
      end
      if (rep_if.valid && rep_if.ready) begin
        if (reports_due.size() == 0) begin
          $error("report word with nothing owed");
          mismatches++;
        end else begin
          want = reports_due.pop_front();
          check_field("char_valid", want.char_valid, rep_if.char_valid);
          check_field("char_code", want.char_code, rep_if.char_code);
          check_field("shift_held", want.shift_held, rep_if.shift_held);
          check_field("ctrl_held", want.ctrl_held, rep_if.ctrl_held);
          check_field("alt_held", want.alt_held, rep_if.alt_held);
          check_field("gui_held", want.gui_held, rep_if.gui_held);
          check_field("text_length", want.text_length, rep_if.text_length);
          check_field("text_first_six", want.text_first_six, rep_if.text_first_six);
          check_field("text_last_six", want.text_last_six, rep_if.text_last_six);
        end
      end
    end
  end

  // watchdog
  initial begin : cycle_guard
    int unsigned cycle_cnt;
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    keys_if.valid = 1'b0;
    keys_if.key_usage = '0;
    keys_if.key_pressed = 1'b0;
    for (int i = 0; i < LOG_DEPTH; i++) begin
      log_chars[i] = hkta_pkg::ASCII_NONE;
    end
    log_len  = '0;
    shift_on = 1'b0;
    ctrl_on  = 1'b0;
    alt_on   = 1'b0;
    gui_on   = 1'b0;

    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed script with idling on both sides
    gaps_on = 1'b1;
    for (int i = 0; i < SCRIPT_ROWS; i++) begin
      offer_key(key_script[i].usage, key_script[i].pressed, key_script[i].fixed,
                key_script[i].want);
    end
    wait_drained();

    // random with idling
    run_random(260);
    wait_drained();

    // no idling at all, with one long report hold-off in the middle while
    // key words keep coming, so the block fills and stalls its input
    gaps_on = 1'b0;
    run_random(80);
    hold_req = 1'b1;
    run_random(80);

    // idling again to the end
    gaps_on = 1'b1;
    run_random(280);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
